// ----- rtl/core/gdo_pkg.sv -----
`timescale 1ns / 1ps

package gdo_pkg;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_RANGE   = 2'd2;

	localparam logic [8:0]  YEAR_CYCLE = 9'd400;
	localparam logic [8:0]  YEAR_LAST_IN_CYCLE = 9'd399;
	localparam logic [15:0] YEAR_MAX = 16'hFFFF;
	localparam logic [15:0] YEAR_MIN = 16'd0;
	localparam logic [3:0]  MONTH_FIRST = 4'd1;
	localparam logic [3:0]  MONTH_LAST = 4'd12;
	localparam logic [4:0]  DAY_FIRST = 5'd1;
	localparam logic [4:0]  DAY_LAST_DEC = 5'd31;

	typedef struct packed {
		logic [4:0]        day;
		logic [3:0]        month;
		logic [15:0]       year;
		logic signed [15:0] offset_days;
	} req_t;

	typedef struct packed {
		logic [4:0]  result_day;
		logic [3:0]  result_month;
		logic [15:0] result_year;
		logic [1:0]  status;
	} rsp_t;

	// Working date; yrem is the year modulo 400, which settles the leap rule.
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic [8:0]  yrem;
	} date_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REM,
		ST_CHECK,
		ST_STEP
	} state_t;

	// Since 400 is a multiple of 100 and of 4, the year modulo 400 decides all three tests.
	function automatic logic is_leap(input logic [8:0] yrem);
		logic century;
		begin
			century = (yrem == 9'd100) || (yrem == 9'd200) || (yrem == 9'd300);
			is_leap = (yrem[1:0] == 2'd0) && !century;
		end
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		begin
			case (month)
				4'd2:                      len = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
				default:                   len = 5'd31;
			endcase
			month_len = len;
		end
	endfunction

endpackage

// ----- rtl/core/gregorian_date_offset.sv -----
`timescale 1ns / 1ps

// Adds a signed number of days to a Gregorian date. A request transfers when start is high
// and busy is low; busy then stays high until the result is presented with done for one
// cycle, and the receiver must take it in that cycle. A request passes through a
// remainder-by-400 on the year, one validity check, one day per cycle from a single-day
// step unit, and a register that presents the result. An invalid start date returns
// unchanged with status 1; a step past 31 Dec 65535 or before 1 Jan 0 stops there with
// status 2.
module gregorian_date_offset (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  gdo_pkg::req_t request,
	output logic          done,
	output gdo_pkg::rsp_t result
);

	gdo_pkg::state_t state_q;
	gdo_pkg::state_t state_d;
	gdo_pkg::date_t  date_q;
	gdo_pkg::date_t  step_nxt;
	gdo_pkg::rsp_t   result_q;
	logic [15:0]     count_q;
	logic            back_q;
	logic            done_q;
	logic            accept;
	logic            rem_done;
	logic [8:0]      rem;
	logic            at_limit;
	logic            date_ok;
	logic            finish;
	logic            do_step;
	logic [1:0]      status_d;
	logic [15:0]     raw;

	assign accept = start && (state_q == gdo_pkg::ST_IDLE);
	assign raw = request.offset_days;

	gdo_mod400 u_mod400 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.year   (request.year),
		.done   (rem_done),
		.rem    (rem)
	);

	gdo_step u_step (
		.cur      (date_q),
		.back     (back_q),
		.nxt      (step_nxt),
		.at_limit (at_limit)
	);

	assign date_ok = (date_q.month >= gdo_pkg::MONTH_FIRST)
		&& (date_q.month <= gdo_pkg::MONTH_LAST)
		&& (date_q.day >= gdo_pkg::DAY_FIRST)
		&& (date_q.day <= gdo_pkg::month_len(date_q.month, gdo_pkg::is_leap(date_q.yrem)));

	always_comb begin
		state_d = state_q;
		finish = 1'b0;
		do_step = 1'b0;
		status_d = gdo_pkg::STATUS_OK;
		case (state_q)
			gdo_pkg::ST_IDLE: begin
				if (start) begin
					state_d = gdo_pkg::ST_REM;
				end
			end
			gdo_pkg::ST_REM: begin
				if (rem_done) begin
					state_d = gdo_pkg::ST_CHECK;
				end
			end
			gdo_pkg::ST_CHECK: begin
				if (date_ok) begin
					state_d = gdo_pkg::ST_STEP;
				end else begin
					finish = 1'b1;
					status_d = gdo_pkg::STATUS_INVALID;
					state_d = gdo_pkg::ST_IDLE;
				end
			end
			gdo_pkg::ST_STEP: begin
				if (count_q == 16'd0) begin
					finish = 1'b1;
					state_d = gdo_pkg::ST_IDLE;
				end else if (at_limit) begin
					finish = 1'b1;
					status_d = gdo_pkg::STATUS_RANGE;
					state_d = gdo_pkg::ST_IDLE;
				end else begin
					do_step = 1'b1;
				end
			end
			default: begin
				state_d = gdo_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdo_pkg::ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			date_q.day <= request.day;
			date_q.month <= request.month;
			date_q.year <= request.year;
			back_q <= raw[15];
			count_q <= raw[15] ? (~raw + 16'd1) : raw;
		end else if (state_q == gdo_pkg::ST_REM && rem_done) begin
			date_q.yrem <= rem;
		end else if (do_step) begin
			date_q <= step_nxt;
			count_q <= count_q - 16'd1;
		end
		if (finish) begin
			result_q.result_day <= date_q.day;
			result_q.result_month <= date_q.month;
			result_q.result_year <= date_q.year;
			result_q.status <= status_d;
		end
	end

	assign busy = (state_q != gdo_pkg::ST_IDLE);
	assign done = done_q;
	assign result = result_q;

endmodule

// ----- rtl/core/gdo_mod400.sv -----
`timescale 1ns / 1ps

// Year modulo 400. Since 400 is 16 times 25, the remainder is the upper twelve
// bits modulo 25, shifted back up, joined with the low four bits. The quotient by 25 comes
// from a multiply by 1311 and a shift by 15, which is exact for every twelve-bit value.
module gdo_mod400 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] year,
	output logic        done,
	output logic [8:0]  rem
);

	localparam logic [22:0] RECIP_25 = 23'd1311;
	localparam logic [11:0] DIV_25 = 12'd25;

	logic [11:0] hi_q;
	logic [3:0]  lo_q;
	logic [7:0]  quot_q;
	logic        run_q;
	logic        done_q;
	logic [22:0] prod;
	logic [11:0] fold;

	assign prod = {11'd0, hi_q} * RECIP_25;
	assign fold = hi_q - {4'd0, quot_q} * DIV_25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= year[15:4];
			lo_q <= year[3:0];
		end
		if (run_q) begin
			quot_q <= prod[22:15];
		end
	end

	assign done = done_q;
	assign rem = {fold[4:0], lo_q};

endmodule

// ----- rtl/core/gdo_step.sv -----
`timescale 1ns / 1ps

// Moves a date by one day in either direction and flags the ends of the year range.
module gdo_step (
	input  gdo_pkg::date_t cur,
	input  logic           back,
	output gdo_pkg::date_t nxt,
	output logic           at_limit
);

	logic       leap_cur;
	logic       leap_prev;
	logic [4:0] len_cur;
	logic [3:0] prev_month;
	logic [15:0] prev_year;
	logic [8:0] prev_yrem;

	always_comb begin
		leap_cur = gdo_pkg::is_leap(cur.yrem);
		len_cur = gdo_pkg::month_len(cur.month, leap_cur);

		// Backward across a month: the new day is the length of the previous month.
		if (cur.month > gdo_pkg::MONTH_FIRST) begin
			prev_month = cur.month - 4'd1;
			prev_year = cur.year;
			prev_yrem = cur.yrem;
		end else begin
			prev_month = gdo_pkg::MONTH_LAST;
			prev_year = cur.year - 16'd1;
			prev_yrem = (cur.yrem == 9'd0) ? gdo_pkg::YEAR_LAST_IN_CYCLE : cur.yrem - 9'd1;
		end
		leap_prev = gdo_pkg::is_leap(prev_yrem);

		nxt = cur;
		if (back) begin
			at_limit = (cur.day == gdo_pkg::DAY_FIRST) && (cur.month == gdo_pkg::MONTH_FIRST)
				&& (cur.year == gdo_pkg::YEAR_MIN);
			if (cur.day > gdo_pkg::DAY_FIRST) begin
				nxt.day = cur.day - 5'd1;
			end else begin
				nxt.month = prev_month;
				nxt.year = prev_year;
				nxt.yrem = prev_yrem;
				nxt.day = gdo_pkg::month_len(prev_month, leap_prev);
			end
		end else begin
			at_limit = (cur.day == gdo_pkg::DAY_LAST_DEC) && (cur.month == gdo_pkg::MONTH_LAST)
				&& (cur.year == gdo_pkg::YEAR_MAX);
			if (cur.day < len_cur) begin
				nxt.day = cur.day + 5'd1;
			end else begin
				nxt.day = gdo_pkg::DAY_FIRST;
				if (cur.month < gdo_pkg::MONTH_LAST) begin
					nxt.month = cur.month + 4'd1;
				end else begin
					nxt.month = gdo_pkg::MONTH_FIRST;
					nxt.year = cur.year + 16'd1;
					nxt.yrem = (cur.yrem == gdo_pkg::YEAR_LAST_IN_CYCLE) ? 9'd0
						: cur.yrem + 9'd1;
				end
			end
		end
	end

endmodule

// ----- dv/gdo_date_checker.sv -----
`timescale 1ns / 1ps

module gdo_date_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  gdo_pkg::req_t request,
	input  logic          done,
	input  gdo_pkg::rsp_t result,
	output int            errors,
	output int            outstanding,
	output int            compared,
	output int            n_invalid,
	output int            n_range
);

	gdo_pkg::rsp_t expected_dates[$];

	function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
		logic leap;
		leap = ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
		case (m)
			2:             return leap ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	// Walks the date one day per iteration, the same way the hardware does.
	function automatic gdo_pkg::rsp_t shift_date(input gdo_pkg::req_t r);
		int unsigned   d;
		int unsigned   m;
		int unsigned   y;
		int            off;
		int unsigned   steps;
		logic          back;
		logic [1:0]    st;
		gdo_pkg::rsp_t o;
		d = r.day;
		m = r.month;
		y = r.year;
		off = int'(r.offset_days);
		back = off < 0;
		steps = back ? -off : off;
		st = gdo_pkg::STATUS_OK;
		if (m < gdo_pkg::MONTH_FIRST || m > gdo_pkg::MONTH_LAST || d < gdo_pkg::DAY_FIRST
			|| d > days_in(m, y)) begin
			st = gdo_pkg::STATUS_INVALID;
		end else if (back) begin
			for (int unsigned i = 0; i < steps; i++) begin
				if (d == gdo_pkg::DAY_FIRST && m == gdo_pkg::MONTH_FIRST
					&& y == gdo_pkg::YEAR_MIN) begin
					st = gdo_pkg::STATUS_RANGE;
					break;
				end
				if (d > 1) begin
					d--;
				end else begin
					if (m > 1) begin
						m--;
					end else begin
						m = 12;
						y--;
					end
					d = days_in(m, y);
				end
			end
		end else begin
			for (int unsigned i = 0; i < steps; i++) begin
				if (d == gdo_pkg::DAY_LAST_DEC && m == gdo_pkg::MONTH_LAST
					&& y == gdo_pkg::YEAR_MAX) begin
					st = gdo_pkg::STATUS_RANGE;
					break;
				end
				if (d < days_in(m, y)) begin
					d++;
				end else begin
					d = 1;
					if (m < 12) begin
						m++;
					end else begin
						m = 1;
						y++;
					end
				end
			end
		end
		o.result_day = d[4:0];
		o.result_month = m[3:0];
		o.result_year = y[15:0];
		o.status = st;
		return o;
	endfunction

	initial begin
		errors = 0;
		outstanding = 0;
		compared = 0;
		n_invalid = 0;
		n_range = 0;
	end

	always @(posedge clk) begin
		gdo_pkg::rsp_t want;
		int            bad;
		bad = 0;
		if (arst_n) begin
			// A result is handled before a request that transfers at the same edge.
			if (done) begin
				if (expected_dates.size() == 0) begin
					$error("result with no request waiting: %p", result);
					bad++;
				end else begin
					want = expected_dates.pop_front();
					if (result.result_day !== want.result_day) begin
						$error("result_day expected %0d actual %0d", want.result_day,
							result.result_day);
						bad++;
					end
					if (result.result_month !== want.result_month) begin
						$error("result_month expected %0d actual %0d", want.result_month,
							result.result_month);
						bad++;
					end
					if (result.result_year !== want.result_year) begin
						$error("result_year expected %0d actual %0d", want.result_year,
							result.result_year);
						bad++;
					end
					if (result.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, result.status);
						bad++;
					end
					compared <= compared + 1;
					if (want.status == gdo_pkg::STATUS_INVALID) n_invalid <= n_invalid + 1;
					if (want.status == gdo_pkg::STATUS_RANGE) n_range <= n_range + 1;
				end
			end
			if (start && !busy) begin
				expected_dates.push_back(shift_date(request));
			end
			outstanding <= expected_dates.size();
			errors <= errors + bad;
		end
	end

endmodule

// ----- dv/gregorian_date_offset_tb.sv -----
`timescale 1ns / 1ps

module gregorian_date_offset_tb;

	localparam int N_RANDOM = 80;
	// Every request could take the longest run plus gaps; allow three times that.
	localparam longint MAX_CYCLES = 3 * (N_RANDOM + 25) * 33000;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	gdo_pkg::req_t request = '0;
	logic          busy;
	logic          done;
	gdo_pkg::rsp_t result;

	int     errors;
	int     outstanding;
	int     compared;
	int     n_invalid;
	int     n_range;
	int     idle_pct;
	int     sent;
	longint cycles = 0;

	gregorian_date_offset i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	gdo_date_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.result      (result),
		.errors      (errors),
		.outstanding (outstanding),
		.compared    (compared),
		.n_invalid   (n_invalid),
		.n_range     (n_range)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= MAX_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Returns at the edge where the request transfers; start is left high.
	task automatic send(input gdo_pkg::req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic send_date(input int d, input int m, input int y, input int off);
		gdo_pkg::req_t r;
		r.day = d[4:0];
		r.month = m[3:0];
		r.year = y[15:0];
		r.offset_days = off[15:0];
		send(r);
	endtask

	task automatic send_random();
		gdo_pkg::req_t r;
		int            ysel;
		int            osel;
		int            off;
		// Mostly well-formed dates; the rest is noise over the full field ranges.
		if ($urandom_range(99) < 85) begin
			r.day = 5'($urandom_range(31, 1));
			r.month = 4'($urandom_range(12, 1));
		end else begin
			r.day = 5'($urandom_range(31));
			r.month = 4'($urandom_range(15));
		end
		ysel = $urandom_range(99);
		if (ysel < 10) r.year = 16'($urandom_range(3));
		else if (ysel < 20) r.year = 16'(65535 - $urandom_range(3));
		else if (ysel < 35) r.year = 16'(100 * $urandom_range(655));
		else r.year = 16'($urandom_range(65535));
		osel = $urandom_range(99);
		if (osel < 70) off = $urandom_range(800) - 400;
		else if (osel < 92) off = $urandom_range(10000) - 5000;
		else off = $urandom_range(65535);
		r.offset_days = off[15:0];
		send(r);
	endtask

	initial begin
		sent = 0;
		idle_pct = 13;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Leap rule corners, month ends and zero offset.
		send_date(29, 2, 2000, 0);
		send_date(29, 2, 1900, 1);
		send_date(29, 2, 2024, 1);
		send_date(28, 2, 2100, 1);
		send_date(31, 1, 2021, 1);
		send_date(1, 3, 2000, -1);
		send_date(1, 1, 2000, -1);
		send_date(30, 4, 1999, 1);
		// Malformed start dates come back unchanged.
		send_date(0, 5, 2020, 5);
		send_date(15, 0, 2020, 3);
		send_date(15, 13, 2020, -3);
		send_date(31, 15, 65535, -1);
		send_date(31, 4, 2021, 2);
		// Year range limits, reached at once and after some stepping.
		send_date(31, 12, 65535, 1);
		send_date(1, 1, 0, -1);
		send_date(25, 12, 65535, 100);
		send_date(5, 1, 0, -10);
		send_date(1, 1, 1, -366);
		send_date(1, 1, 1, -367);
		// Largest offsets in both directions.
		send_date(1, 1, 0, 32767);
		send_date(31, 12, 65535, -32768);
		send_date(1, 1, 0, -32768);
		send_date(31, 12, 65535, 32767);
		drain();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				drain();
				idle_pct = 69;
			end else if (i == 2 * N_RANDOM / 3) begin
				drain();
				idle_pct = 0;
			end
			send_random();
		end
		drain();
		repeat (40) @(posedge clk);

		$display("Sent %0d date offset requests under three idle patterns; %0d results compared.",
			sent, compared);
		$display("Statuses seen: %0d ok, %0d invalid start date, %0d year range exceeded.",
			compared - n_invalid - n_range, n_invalid, n_range);
		if (errors == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/gdo_pkg.sv
rtl/core/gdo_mod400.sv
rtl/core/gdo_step.sv
rtl/core/gregorian_date_offset.sv
dv/gdo_date_checker.sv
dv/gregorian_date_offset_tb.sv
